>>> hw/rtl/tempo_map_tick_frame_converter_defines.svh
// Assertion macros shared by the tempo map converter RTL.
`ifndef TEMPO_MAP_TICK_FRAME_CONVERTER_DEFINES_SVH
`define TEMPO_MAP_TICK_FRAME_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TMTFC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmtfc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TMTFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmtfc assertion failed");

`endif

>>> hw/rtl/tmtfc_pkg.sv
// Types, codes and constants of the tempo map converter.
`timescale 1ns / 1ps
package tmtfc_pkg;

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_DEL    = 3'd1;
	localparam logic [2:0] CMD_CHG    = 3'd2;
	localparam logic [2:0] CMD_RECOMP = 3'd3;
	localparam logic [2:0] CMD_QTEMPO = 3'd4;
	localparam logic [2:0] CMD_T2F    = 3'd5;
	localparam logic [2:0] CMD_F2T    = 3'd6;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_SENTINEL  = 2'd3;

	localparam logic [2:0] CFG_USE_LIST = 3'd0;
	localparam logic [2:0] CFG_FIXED    = 3'd1;
	localparam logic [2:0] CFG_PERCENT  = 3'd2;
	localparam logic [2:0] CFG_TPQ      = 3'd3;
	localparam logic [2:0] CFG_SRATE    = 3'd4;

	localparam logic [23:0] RESET_TEMPO   = 24'd500000;
	localparam logic [23:0] NO_TEMPO      = 24'd1000;
	localparam logic [23:0] PERCENT_SCALE = 24'd10000;
	localparam logic [9:0]  RESET_PERCENT = 10'd100;
	localparam logic [15:0] RESET_TPQ     = 16'd384;
	localparam logic [18:0] RESET_SRATE   = 19'd44100;
	localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;

	typedef logic [4:0] dp_op_t;
	localparam dp_op_t OP_NOP        = 5'd0;
	localparam dp_op_t OP_LATCH      = 5'd1;
	localparam dp_op_t OP_RD         = 5'd2;
	localparam dp_op_t OP_RD1        = 5'd3;
	localparam dp_op_t OP_FCMP       = 5'd4;
	localparam dp_op_t OP_HOLD       = 5'd5;
	localparam dp_op_t OP_WCMP       = 5'd6;
	localparam dp_op_t OP_SET_TEMPO  = 5'd7;
	localparam dp_op_t OP_SPLIT_INIT = 5'd8;
	localparam dp_op_t OP_SH_RD      = 5'd9;
	localparam dp_op_t OP_SH_WR_UP   = 5'd10;
	localparam dp_op_t OP_SPLIT_HI   = 5'd11;
	localparam dp_op_t OP_SPLIT_LO   = 5'd12;
	localparam dp_op_t OP_DEL_INIT   = 5'd13;
	localparam dp_op_t OP_DEL_FIRST  = 5'd14;
	localparam dp_op_t OP_SH_WR_DN   = 5'd15;
	localparam dp_op_t OP_DEL_END    = 5'd16;
	localparam dp_op_t OP_BUMP       = 5'd17;
	localparam dp_op_t OP_RC_INIT    = 5'd18;
	localparam dp_op_t OP_RC_CONV    = 5'd19;
	localparam dp_op_t OP_RC_WR      = 5'd20;
	localparam dp_op_t OP_FIX_ENT    = 5'd21;
	localparam dp_op_t OP_CONV       = 5'd22;
	localparam dp_op_t OP_RES        = 5'd23;
	localparam dp_op_t OP_RES_TEMPO  = 5'd24;
	localparam dp_op_t OP_MISS       = 5'd25;
	localparam dp_op_t OP_FULL       = 5'd26;
	localparam dp_op_t OP_SENT       = 5'd27;
	localparam dp_op_t OP_DONE       = 5'd28;

	typedef struct packed {
		logic [31:0] end_tick;
		logic [30:0] start_tick;
		logic [23:0] tempo;
		logic [31:0] start_frame;
	} entry_t;

	typedef struct packed {
		logic        use_list;
		logic [23:0] fixed_tempo;
		logic [9:0]  percent;
		logic [15:0] tpq;
		logic [18:0] srate;
	} cfg_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       use_list;
		logic       redo;
		logic       hit;
		logic       last;
		logic       start_eq;
		logic       full;
		logic       ptr_gt_idx;
		logic       ptr_lt_count;
		logic       adv;
		logic       conv_busy;
	} dp_stat_t;

endpackage

>>> hw/rtl/tmtfc_conv.sv
// Sequential rational converter: shift-add products, restoring divide, ties-to-even round.
`timescale 1ns / 1ps
module tmtfc_conv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               f2t,
	input  logic [31:0]        delta,
	input  logic [23:0]        tempo,
	input  tmtfc_pkg::cfg_t    cfg,
	output logic               busy,
	output logic [31:0]        result
);
	import tmtfc_pkg::*;

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_LD   = 3'd1;
	localparam logic [2:0] C_MUL  = 3'd2;
	localparam logic [2:0] C_DIV  = 3'd3;
	localparam logic [2:0] C_RND  = 3'd4;

	logic [2:0]  state_q;
	logic [1:0]  step_q;
	logic [6:0]  cnt_q;
	logic        f2t_q;
	logic [31:0] delta_q;
	logic [23:0] tempo_q;
	logic [75:0] a_q, acc_q, mc_q;
	logic [43:0] b_q, rem_q;
	logic [23:0] mp_q;
	logic [31:0] res_q;

	logic [75:0] x_w, acc_nx;
	logic [23:0] y_w;
	logic        dst_b;
	logic [44:0] trial, r2, bx;
	logic        up;
	logic [76:0] q1;

	// operand schedule: numerator product into a, divisor product into b
	always_comb begin
		x_w   = a_q;
		y_w   = '0;
		dst_b = 1'b0;
		if (!f2t_q) begin
			unique case (step_q)
				2'd0: begin x_w = 76'(delta_q); y_w = tempo_q; end
				2'd1: begin x_w = a_q; y_w = 24'(cfg.srate); end
				2'd2: begin x_w = 76'(cfg.tpq); y_w = 24'(cfg.percent); dst_b = 1'b1; end
				2'd3: begin x_w = 76'(b_q); y_w = PERCENT_SCALE; dst_b = 1'b1; end
				default: ;
			endcase
		end else begin
			unique case (step_q)
				2'd0: begin x_w = 76'(delta_q); y_w = 24'(cfg.percent); end
				2'd1: begin x_w = a_q; y_w = 24'(cfg.tpq); end
				2'd2: begin x_w = a_q; y_w = PERCENT_SCALE; end
				2'd3: begin x_w = 76'(cfg.srate); y_w = tempo_q; dst_b = 1'b1; end
				default: ;
			endcase
		end
	end

	assign acc_nx = mp_q[0] ? acc_q + mc_q : acc_q;
	assign trial  = {rem_q, a_q[75]};
	assign bx     = {1'b0, b_q};
	assign r2     = {rem_q, 1'b0};
	assign up     = (r2 > bx) || ((r2 == bx) && a_q[0]);
	assign q1     = {1'b0, a_q} + 77'(up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_LD;
						step_q  <= '0;
					end
				end
				C_LD: begin
					state_q <= C_MUL;
					cnt_q   <= '0;
				end
				C_MUL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd23) begin
						cnt_q <= '0;
						if (step_q == 2'd3) begin
							state_q <= C_DIV;
						end else begin
							state_q <= C_LD;
							step_q  <= step_q + 2'd1;
						end
					end
				end
				C_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd75) begin
						state_q <= C_RND;
					end
				end
				C_RND: state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			f2t_q   <= f2t;
			delta_q <= delta;
			tempo_q <= tempo;
		end
		if (state_q == C_LD) begin
			mc_q  <= x_w;
			mp_q  <= y_w;
			acc_q <= '0;
		end
		if (state_q == C_MUL) begin
			acc_q <= acc_nx;
			mc_q  <= {mc_q[74:0], 1'b0};
			mp_q  <= {1'b0, mp_q[23:1]};
			if (cnt_q == 7'd23) begin
				if (dst_b) begin
					b_q <= acc_nx[43:0];
				end else begin
					a_q <= acc_nx;
				end
				if (step_q == 2'd3) begin
					rem_q <= '0;
				end
			end
		end
		if (state_q == C_DIV) begin
			// quotient bits shift into a while the dividend shifts out
			if (trial >= bx) begin
				rem_q <= 44'(trial - bx);
				a_q   <= {a_q[74:0], 1'b1};
			end else begin
				rem_q <= trial[43:0];
				a_q   <= {a_q[74:0], 1'b0};
			end
		end
		if (state_q == C_RND) begin
			if (b_q == '0 || (|q1[76:32])) begin
				res_q <= SAT32;
			end else begin
				res_q <= q1[31:0];
			end
		end
	end

	assign busy   = (state_q != C_IDLE);
	assign result = res_q;

endmodule

>>> hw/rtl/tmtfc_dp.sv
// Datapath: segment table memory, config registers, walk pointers and results.
`timescale 1ns / 1ps
module tmtfc_dp #(
	parameter int TABLE_DEPTH = 64,
	parameter int TICK_LIMIT  = 2147483647
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmtfc_pkg::dp_op_t     op,
	output tmtfc_pkg::dp_stat_t   stat,
	input  logic [2:0]            command,
	input  logic [30:0]           tick_value,
	input  logic [23:0]           tempo_value,
	input  logic [31:0]           frame_value,
	input  logic                  recompute_frames,
	input  logic                  cfg_wr,
	input  logic [2:0]            cfg_index,
	input  logic [23:0]           cfg_data,
	output logic                  done,
	output logic [1:0]            status,
	output logic [23:0]           tempo_out,
	output logic [31:0]           frame_out,
	output logic [31:0]           tick_out,
	output logic [31:0]           change_count
);
	import tmtfc_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [30:0] TLIM = 31'(TICK_LIMIT);
	localparam logic [31:0] SENT_END = {1'b0, TLIM} + 32'd1;

	cfg_t        cfg_q;
	logic [2:0]  cmd_q;
	logic [30:0] tick_q;
	logic [23:0] tempo_q;
	logic [31:0] frame_q;
	logic        redo_q;
	logic [CW-1:0] count_q, ptr_q;
	logic [IW-1:0] idx_q;
	logic [31:0] serial_q, acc_q;
	entry_t      ent_q, mem_q, rdata, wdata;
	logic        rd0_q, e0_q;
	logic [1:0]  status_q;
	logic [23:0] tempo_out_q;
	logic [31:0] frame_out_q, tick_out_q;
	logic        done_q;

	entry_t      mem [TABLE_DEPTH];

	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	logic          conv_start, conv_f2t, conv_busy;
	logic [31:0]   conv_delta, conv_res;
	logic [23:0]   conv_tempo;
	logic [32:0]   sum_res;
	logic [31:0]   sum_base;

	// entry 0 reads as the sentinel until it is first written
	assign rdata = (rd0_q && !e0_q) ? '{end_tick: SENT_END, start_tick: '0,
		tempo: RESET_TEMPO, start_frame: '0} : mem_q;

	always_comb begin
		rd_en   = 1'b1;
		rd_addr = idx_q;
		unique case (op)
			OP_RD:    rd_addr = idx_q;
			OP_RD1:   rd_addr = idx_q + IW'(1);
			OP_SH_RD: rd_addr = ptr_q[IW-1:0];
			default:  rd_en = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_q;
		wdata   = ent_q;
		unique case (op)
			OP_SET_TEMPO: wdata.tempo = tempo_q;
			OP_SH_WR_UP: begin
				wr_addr = IW'(ptr_q + CW'(1));
				wdata   = rdata;
			end
			OP_SPLIT_HI: begin
				wr_addr          = idx_q + IW'(1);
				wdata.start_tick = tick_q;
				wdata.tempo      = tempo_q;
			end
			OP_SPLIT_LO: wdata.end_tick = {1'b0, tick_q};
			OP_DEL_FIRST: begin
				wdata            = rdata;
				wdata.start_tick = ent_q.start_tick;
				wdata.tempo      = ent_q.tempo;
			end
			OP_SH_WR_DN: begin
				wr_addr = IW'(ptr_q - CW'(1));
				wdata   = rdata;
			end
			OP_RC_WR: wdata.start_frame = acc_q;
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd0_q <= 1'b0;
			e0_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				rd0_q <= (rd_addr == '0);
			end
			if (wr_en && wr_addr == '0) begin
				e0_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{use_list: 1'b1, fixed_tempo: RESET_TEMPO, percent: RESET_PERCENT,
				tpq: RESET_TPQ, srate: RESET_SRATE};
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_USE_LIST: cfg_q.use_list    <= cfg_data[0];
				CFG_FIXED:    cfg_q.fixed_tempo <= cfg_data;
				CFG_PERCENT:  cfg_q.percent     <= cfg_data[9:0];
				CFG_TPQ:      cfg_q.tpq         <= cfg_data[15:0];
				CFG_SRATE:    cfg_q.srate       <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		conv_start = (op == OP_CONV) || (op == OP_RC_CONV);
		conv_f2t   = (op == OP_CONV) && (cmd_q == CMD_F2T);
		conv_tempo = ent_q.tempo;
		conv_delta = '0;
		if (op == OP_RC_CONV) begin
			conv_tempo = rdata.tempo;
			if (rdata.end_tick >= {1'b0, rdata.start_tick}) begin
				conv_delta = rdata.end_tick - {1'b0, rdata.start_tick};
			end
		end else if (cmd_q == CMD_F2T) begin
			if (frame_q >= ent_q.start_frame) begin
				conv_delta = frame_q - ent_q.start_frame;
			end
		end else if (tick_q >= ent_q.start_tick) begin
			conv_delta = {1'b0, tick_q - ent_q.start_tick};
		end
	end

	tmtfc_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.f2t    (conv_f2t),
		.delta  (conv_delta),
		.tempo  (conv_tempo),
		.cfg    (cfg_q),
		.busy   (conv_busy),
		.result (conv_res)
	);

	always_comb begin
		priority if (op == OP_RC_WR) begin
			sum_base = acc_q;
		end else if (cmd_q == CMD_F2T) begin
			sum_base = {1'b0, ent_q.start_tick};
		end else begin
			sum_base = ent_q.start_frame;
		end
	end
	assign sum_res = {1'b0, sum_base} + {1'b0, conv_res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CW'(1);
			serial_q <= 32'd1;
			idx_q    <= '0;
			ptr_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (op == OP_DONE);
			unique case (op)
				OP_LATCH:      idx_q <= '0;
				OP_FCMP:       if (!stat.hit) idx_q <= idx_q + IW'(1);
				OP_WCMP:       if (stat.adv) idx_q <= idx_q + IW'(1);
				OP_SPLIT_INIT: ptr_q <= count_q - CW'(1);
				OP_SH_WR_UP:   ptr_q <= ptr_q - CW'(1);
				OP_SPLIT_LO:   count_q <= count_q + CW'(1);
				OP_DEL_INIT:   ptr_q <= CW'(idx_q) + CW'(1);
				OP_DEL_FIRST:  ptr_q <= ptr_q + CW'(1);
				OP_SH_WR_DN:   ptr_q <= ptr_q + CW'(1);
				OP_DEL_END:    count_q <= count_q - CW'(1);
				OP_BUMP:       serial_q <= serial_q + 32'd1;
				OP_RC_INIT:    idx_q <= '0;
				OP_RC_WR:      idx_q <= idx_q + IW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LATCH: begin
				cmd_q       <= command;
				tick_q      <= (command == CMD_ADD && tick_value > TLIM) ? TLIM : tick_value;
				tempo_q     <= tempo_value;
				frame_q     <= frame_value;
				redo_q      <= recompute_frames;
				status_q    <= ST_OK;
				tempo_out_q <= '0;
				frame_out_q <= '0;
				tick_out_q  <= '0;
			end
			OP_FCMP:      if (stat.hit) ent_q <= rdata;
			OP_HOLD:      ent_q <= rdata;
			OP_WCMP:      if (stat.adv) ent_q <= rdata;
			OP_RC_CONV:   ent_q <= rdata;
			OP_RC_INIT:   acc_q <= '0;
			OP_RC_WR:     acc_q <= sum_res[32] ? SAT32 : sum_res[31:0];
			OP_FIX_ENT:   ent_q <= '{end_tick: '0, start_tick: '0,
				tempo: cfg_q.fixed_tempo, start_frame: '0};
			OP_RES: begin
				if (cmd_q == CMD_F2T) begin
					tick_out_q <= sum_res[32] ? SAT32 : sum_res[31:0];
				end else begin
					frame_out_q <= sum_res[32] ? SAT32 : sum_res[31:0];
				end
			end
			OP_RES_TEMPO: tempo_out_q <= ent_q.tempo;
			OP_MISS: begin
				status_q <= ST_NOT_FOUND;
				if (cmd_q == CMD_QTEMPO) tempo_out_q <= NO_TEMPO;
			end
			OP_FULL:      status_q <= ST_FULL;
			OP_SENT:      status_q <= ST_SENTINEL;
			default: ;
		endcase
	end

	always_comb begin
		stat.cmd          = cmd_q;
		stat.use_list     = cfg_q.use_list;
		stat.redo         = redo_q;
		stat.hit          = (cmd_q == CMD_DEL || cmd_q == CMD_CHG)
			? (rdata.end_tick == {1'b0, tick_q}) : (rdata.end_tick > {1'b0, tick_q});
		stat.last         = (CW'(idx_q) + CW'(1)) >= count_q;
		stat.start_eq     = (ent_q.start_tick == tick_q);
		stat.full         = count_q >= CW'(TABLE_DEPTH);
		stat.ptr_gt_idx   = ptr_q > CW'(idx_q);
		stat.ptr_lt_count = ptr_q < count_q;
		stat.adv          = frame_q >= rdata.start_frame;
		stat.conv_busy    = conv_busy;
	end

	assign done         = done_q;
	assign status       = status_q;
	assign tempo_out    = tempo_out_q;
	assign frame_out    = frame_out_q;
	assign tick_out     = tick_out_q;
	assign change_count = serial_q;

endmodule

>>> hw/rtl/tmtfc_ctrl.sv
// Controller: sequences table searches, shifts, recomputes and conversions.
`timescale 1ns / 1ps
module tmtfc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  tmtfc_pkg::dp_stat_t  stat,
	output tmtfc_pkg::dp_op_t    op,
	output logic                 busy
);
	import tmtfc_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_FRD    = 5'd2;
	localparam logic [4:0] S_FCMP   = 5'd3;
	localparam logic [4:0] S_MISS   = 5'd4;
	localparam logic [4:0] S_ADD    = 5'd5;
	localparam logic [4:0] S_SETT   = 5'd6;
	localparam logic [4:0] S_BUMP   = 5'd7;
	localparam logic [4:0] S_RCI    = 5'd8;
	localparam logic [4:0] S_SHCHK  = 5'd9;
	localparam logic [4:0] S_SHUP   = 5'd10;
	localparam logic [4:0] S_SPHI   = 5'd11;
	localparam logic [4:0] S_SPLO   = 5'd12;
	localparam logic [4:0] S_FULL   = 5'd13;
	localparam logic [4:0] S_DEL    = 5'd14;
	localparam logic [4:0] S_SENT   = 5'd15;
	localparam logic [4:0] S_DRD0   = 5'd16;
	localparam logic [4:0] S_DFST   = 5'd17;
	localparam logic [4:0] S_DCHK   = 5'd18;
	localparam logic [4:0] S_DDN    = 5'd19;
	localparam logic [4:0] S_RRD    = 5'd20;
	localparam logic [4:0] S_RCV    = 5'd21;
	localparam logic [4:0] S_RWT    = 5'd22;
	localparam logic [4:0] S_RTEMPO = 5'd23;
	localparam logic [4:0] S_CONV   = 5'd24;
	localparam logic [4:0] S_CWT    = 5'd25;
	localparam logic [4:0] S_WRD0   = 5'd26;
	localparam logic [4:0] S_WHOLD  = 5'd27;
	localparam logic [4:0] S_WCHK   = 5'd28;
	localparam logic [4:0] S_WCMP   = 5'd29;
	localparam logic [4:0] S_DONE   = 5'd30;

	logic [4:0] state_q, nxt;

	always_comb begin
		op  = OP_NOP;
		nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op  = OP_LATCH;
					nxt = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.cmd)
					CMD_ADD, CMD_DEL, CMD_CHG: nxt = S_FRD;
					CMD_RECOMP: nxt = S_RCI;
					CMD_QTEMPO: begin
						if (stat.use_list) begin
							nxt = S_FRD;
						end else begin
							op  = OP_FIX_ENT;
							nxt = S_RTEMPO;
						end
					end
					CMD_T2F: begin
						if (stat.use_list) begin
							nxt = S_FRD;
						end else begin
							op  = OP_FIX_ENT;
							nxt = S_CONV;
						end
					end
					CMD_F2T: begin
						if (stat.use_list) begin
							nxt = S_WRD0;
						end else begin
							op  = OP_FIX_ENT;
							nxt = S_CONV;
						end
					end
					default: nxt = S_DONE;
				endcase
			end
			S_FRD: begin
				op  = OP_RD;
				nxt = S_FCMP;
			end
			S_FCMP: begin
				op = OP_FCMP;
				if (stat.hit) begin
					unique case (stat.cmd)
						CMD_ADD:    nxt = S_ADD;
						CMD_DEL:    nxt = S_DEL;
						CMD_CHG:    nxt = S_SETT;
						CMD_QTEMPO: nxt = S_RTEMPO;
						CMD_T2F:    nxt = S_CONV;
						default:    nxt = S_DONE;
					endcase
				end else if (stat.last) begin
					nxt = S_MISS;
				end else begin
					nxt = S_FRD;
				end
			end
			S_MISS: begin
				op  = OP_MISS;
				nxt = S_DONE;
			end
			S_ADD: begin
				priority if (stat.start_eq) begin
					nxt = S_SETT;
				end else if (stat.full) begin
					nxt = S_FULL;
				end else begin
					op  = OP_SPLIT_INIT;
					nxt = S_SHCHK;
				end
			end
			S_SETT: begin
				op  = OP_SET_TEMPO;
				nxt = S_BUMP;
			end
			S_BUMP: begin
				op  = OP_BUMP;
				nxt = (stat.cmd == CMD_ADD && !stat.redo) ? S_DONE : S_RCI;
			end
			S_RCI: begin
				op  = OP_RC_INIT;
				nxt = S_RRD;
			end
			S_SHCHK: begin
				if (stat.ptr_gt_idx) begin
					op  = OP_SH_RD;
					nxt = S_SHUP;
				end else begin
					nxt = S_SPHI;
				end
			end
			S_SHUP: begin
				op  = OP_SH_WR_UP;
				nxt = S_SHCHK;
			end
			S_SPHI: begin
				op  = OP_SPLIT_HI;
				nxt = S_SPLO;
			end
			S_SPLO: begin
				op  = OP_SPLIT_LO;
				nxt = S_BUMP;
			end
			S_FULL: begin
				op  = OP_FULL;
				nxt = S_DONE;
			end
			S_DEL: begin
				if (stat.last) begin
					nxt = S_SENT;
				end else begin
					op  = OP_DEL_INIT;
					nxt = S_DRD0;
				end
			end
			S_SENT: begin
				op  = OP_SENT;
				nxt = S_DONE;
			end
			S_DRD0: begin
				op  = OP_SH_RD;
				nxt = S_DFST;
			end
			S_DFST: begin
				op  = OP_DEL_FIRST;
				nxt = S_DCHK;
			end
			S_DCHK: begin
				if (stat.ptr_lt_count) begin
					op  = OP_SH_RD;
					nxt = S_DDN;
				end else begin
					op  = OP_DEL_END;
					nxt = S_BUMP;
				end
			end
			S_DDN: begin
				op  = OP_SH_WR_DN;
				nxt = S_DCHK;
			end
			S_RRD: begin
				op  = OP_RD;
				nxt = S_RCV;
			end
			S_RCV: begin
				op  = OP_RC_CONV;
				nxt = S_RWT;
			end
			S_RWT: begin
				if (!stat.conv_busy) begin
					op  = OP_RC_WR;
					nxt = stat.last ? S_DONE : S_RRD;
				end
			end
			S_RTEMPO: begin
				op  = OP_RES_TEMPO;
				nxt = S_DONE;
			end
			S_CONV: begin
				op  = OP_CONV;
				nxt = S_CWT;
			end
			S_CWT: begin
				if (!stat.conv_busy) begin
					op  = OP_RES;
					nxt = S_DONE;
				end
			end
			S_WRD0: begin
				op  = OP_RD;
				nxt = S_WHOLD;
			end
			S_WHOLD: begin
				op  = OP_HOLD;
				nxt = S_WCHK;
			end
			S_WCHK: begin
				if (stat.last) begin
					nxt = S_CONV;
				end else begin
					op  = OP_RD1;
					nxt = S_WCMP;
				end
			end
			S_WCMP: begin
				op  = OP_WCMP;
				nxt = stat.adv ? S_WCHK : S_CONV;
			end
			S_DONE: begin
				op  = OP_DONE;
				nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> hw/rtl/tempo_map_tick_frame_converter.sv
// Tempo map tick/frame converter, top level.
// Queries in list mode search the table segment by segment; a conversion then runs through the shift-add
// multiplier and 76-step restoring divider of the conversion unit.
// Edits: a search, then one read and one write per shifted segment; a recompute converts
// every segment. One request at a time; the result strobe lasts one cycle, no stall.
// Reset is asynchronous; the table reads as the single sentinel at once, no clearing pass.
`timescale 1ns / 1ps
`include "tempo_map_tick_frame_converter_defines.svh"
module tempo_map_tick_frame_converter #(
	parameter int TABLE_DEPTH = 64,
	parameter int TICK_LIMIT  = 2147483647
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [30:0] tick_value,
	input  logic [23:0] tempo_value,
	input  logic [31:0] frame_value,
	input  logic        recompute_frames,
	output logic        done,
	output logic [1:0]  status,
	output logic [23:0] tempo_out,
	output logic [31:0] frame_out,
	output logic [31:0] tick_out,
	output logic [31:0] change_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import tmtfc_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	tmtfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	tmtfc_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TICK_LIMIT  (TICK_LIMIT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.stat             (stat),
		.command          (command),
		.tick_value       (tick_value),
		.tempo_value      (tempo_value),
		.frame_value      (frame_value),
		.recompute_frames (recompute_frames),
		.cfg_wr           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.done             (done),
		.status           (status),
		.tempo_out        (tempo_out),
		.frame_out        (frame_out),
		.tick_out         (tick_out),
		.change_count     (change_count)
	);

	`TMTFC_ASSERT_NEXT(a_busy_after_req, start && !busy, busy && !done)
	`TMTFC_ASSERT_NOW(a_done_when_idle, done, !busy)
	`TMTFC_ASSERT_NEXT(a_done_single, done, !done)

endmodule
